// ===== rtl/core/tcpa_pkg.sv =====
`timescale 1ns / 1ps

package tcpa_pkg;

  // Widths of the fixed fields.
  localparam int ID_W  = 8;
  localparam int OCC_W = 8;
  localparam int ERR_W = 2;

  // Capacity after reset.
  localparam logic [OCC_W-1:0] CAPACITY_RESET = 8'd5;

  // Action codes of an input word.
  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_LEAVE  = 1'b1;

  // Error codes of a result word.
  typedef enum logic [ERR_W-1:0] {
    ERR_OK          = 2'd0,
    ERR_QUEUE_FULL  = 2'd1,
    ERR_LEAVE_EMPTY = 2'd2
  } tcpa_err_t;

  // Control sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } tcpa_state_t;

  // Commands from the controller to one waiting queue.
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] data;
  } tcpa_qcmd_t;

  // Status of one waiting queue.
  typedef struct packed {
    logic empty;
    logic full;
  } tcpa_qstat_t;

endpackage

// ===== rtl/core/tcpa_queue.sv =====
`timescale 1ns / 1ps

module tcpa_queue #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcpa_pkg::tcpa_qcmd_t       cmd,
  output tcpa_pkg::tcpa_qstat_t      stat,
  output logic [tcpa_pkg::ID_W-1:0]  rd_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [tcpa_pkg::ID_W-1:0] mem [DEPTH];

  logic [IW-1:0] head_r;
  logic [IW-1:0] head_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_wrap;
  logic [IW-1:0] tail;

  // Tail slot is head plus count, wrapped once around the ring.
  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (tail_sum >= (CW+1)'(DEPTH)) begin
      tail_wrap = tail_sum - (CW+1)'(DEPTH);
    end else begin
      tail_wrap = tail_sum;
    end
    tail = tail_wrap[IW-1:0];
  end

  // Head advances on a pop; count follows pushes and pops.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      if (head_r == IW'(DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + 1'b1;
      end
    end
    if (cmd.push && !cmd.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop && !cmd.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage: one write port at the tail, one registered read port at the head.
  // A push and a pop never fall in the same cycle, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_data <= mem[head_r];
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

endmodule

// ===== rtl/core/two_class_priority_admission.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                                     Direction
// in        in_valid, in_stall, in_action, in_client_id, in_is_vip    word in
// out       out_valid, out_stall, out_grant_valid, out_granted_id,    word out
//           out_granted_vip, out_occupancy, out_error_code
// cfg       cfg_wr_en, cfg_wr_data (capacity)                         write only
//
// An arrival, or a leave that admits nobody, has its result registered as soon
// as it is taken. A leave that admits a waiting requester first passes through
// the read state: the head entry is read from the queue memory, whose read data
// is registered, before the result is formed. Reset clears the counters, the
// queue pointers and the result valid flag and sets capacity to 5. A new word is
// taken in the idle state while the result register is empty or being drained.

module two_class_priority_admission #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [tcpa_pkg::ID_W-1:0]     in_client_id,
  input  logic                          in_is_vip,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_grant_valid,
  output logic [tcpa_pkg::ID_W-1:0]     out_granted_id,
  output logic                          out_granted_vip,
  output logic [tcpa_pkg::OCC_W-1:0]    out_occupancy,
  output logic [tcpa_pkg::ERR_W-1:0]    out_error_code,
  input  logic                          cfg_wr_en,
  input  logic [tcpa_pkg::OCC_W-1:0]    cfg_wr_data
);

  tcpa_pkg::tcpa_state_t     state_r;
  tcpa_pkg::tcpa_state_t     state_nxt;
  logic [tcpa_pkg::OCC_W-1:0] inside_r;
  logic [tcpa_pkg::OCC_W-1:0] inside_nxt;
  logic [tcpa_pkg::OCC_W-1:0] capacity_r;
  logic                      sel_vip_r;
  logic                      sel_vip_nxt;

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      out_load;
  logic                      out_grant_valid_r;
  logic                      out_grant_valid_nxt;
  logic [tcpa_pkg::ID_W-1:0] out_granted_id_r;
  logic [tcpa_pkg::ID_W-1:0] out_granted_id_nxt;
  logic                      out_granted_vip_r;
  logic                      out_granted_vip_nxt;
  logic [tcpa_pkg::OCC_W-1:0] out_occupancy_r;
  logic [tcpa_pkg::OCC_W-1:0] out_occupancy_nxt;
  tcpa_pkg::tcpa_err_t       out_error_r;
  tcpa_pkg::tcpa_err_t       out_error_nxt;

  tcpa_pkg::tcpa_qcmd_t      vip_cmd;
  tcpa_pkg::tcpa_qcmd_t      norm_cmd;
  tcpa_pkg::tcpa_qstat_t     vip_stat;
  tcpa_pkg::tcpa_qstat_t     norm_stat;
  logic [tcpa_pkg::ID_W-1:0] vip_rd;
  logic [tcpa_pkg::ID_W-1:0] norm_rd;

  logic                      out_free;
  logic                      in_accept;
  logic                      room;
  logic [tcpa_pkg::OCC_W-1:0] inside_dec;

  // Waiting queues, one per class.
  tcpa_queue #(.DEPTH(QUEUE_DEPTH)) u_vip_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (vip_cmd),
    .stat    (vip_stat),
    .rd_data (vip_rd)
  );

  tcpa_queue #(.DEPTH(QUEUE_DEPTH)) u_norm_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (norm_cmd),
    .stat    (norm_stat),
    .rd_data (norm_rd)
  );

  // Handshake on the input side.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != tcpa_pkg::ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;

  assign room       = (inside_r < capacity_r);
  assign inside_dec = inside_r - 1'b1;

  // Next state, queue commands and the result word.
  always_comb begin
    state_nxt           = state_r;
    inside_nxt          = inside_r;
    sel_vip_nxt         = sel_vip_r;
    out_load            = 1'b0;
    out_grant_valid_nxt = 1'b0;
    out_granted_id_nxt  = '0;
    out_granted_vip_nxt = 1'b0;
    out_occupancy_nxt   = inside_r;
    out_error_nxt       = tcpa_pkg::ERR_OK;
    vip_cmd.push        = 1'b0;
    vip_cmd.pop         = 1'b0;
    vip_cmd.data        = in_client_id;
    norm_cmd.push       = 1'b0;
    norm_cmd.pop        = 1'b0;
    norm_cmd.data       = in_client_id;

    unique case (state_r)
      tcpa_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_action == tcpa_pkg::ACT_ARRIVE) begin
            out_load = 1'b1;
            if (in_is_vip) begin
              if (room && vip_stat.empty) begin
                inside_nxt          = inside_r + 1'b1;
                out_grant_valid_nxt = 1'b1;
                out_granted_id_nxt  = in_client_id;
                out_granted_vip_nxt = 1'b1;
              end else if (!vip_stat.full) begin
                vip_cmd.push = 1'b1;
              end else begin
                out_error_nxt = tcpa_pkg::ERR_QUEUE_FULL;
              end
            end else begin
              if (room && norm_stat.empty && vip_stat.empty) begin
                inside_nxt          = inside_r + 1'b1;
                out_grant_valid_nxt = 1'b1;
                out_granted_id_nxt  = in_client_id;
              end else if (!norm_stat.full) begin
                norm_cmd.push = 1'b1;
              end else begin
                out_error_nxt = tcpa_pkg::ERR_QUEUE_FULL;
              end
            end
            out_occupancy_nxt = inside_nxt;
          end else begin
            // A leave frees a place and may hand it straight to a waiter.
            if (inside_r == '0) begin
              out_load      = 1'b1;
              out_error_nxt = tcpa_pkg::ERR_LEAVE_EMPTY;
            end else if ((inside_dec < capacity_r) && !vip_stat.empty) begin
              vip_cmd.pop = 1'b1;
              sel_vip_nxt = 1'b1;
              state_nxt   = tcpa_pkg::ST_READ;
            end else if ((inside_dec < capacity_r) && !norm_stat.empty) begin
              norm_cmd.pop = 1'b1;
              sel_vip_nxt  = 1'b0;
              state_nxt    = tcpa_pkg::ST_READ;
            end else begin
              out_load          = 1'b1;
              inside_nxt        = inside_dec;
              out_occupancy_nxt = inside_dec;
            end
          end
        end
      end
      tcpa_pkg::ST_READ: begin
        // Head entry is now on the read port; occupancy stays the same.
        out_load            = 1'b1;
        out_grant_valid_nxt = 1'b1;
        out_granted_id_nxt  = sel_vip_r ? vip_rd : norm_rd;
        out_granted_vip_nxt = sel_vip_r;
        state_nxt           = tcpa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcpa_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcpa_pkg::ST_IDLE;
      inside_r    <= '0;
      sel_vip_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inside_r    <= inside_nxt;
      sel_vip_r   <= sel_vip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= tcpa_pkg::CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_grant_valid_r <= out_grant_valid_nxt;
      out_granted_id_r  <= out_granted_id_nxt;
      out_granted_vip_r <= out_granted_vip_nxt;
      out_occupancy_r   <= out_occupancy_nxt;
      out_error_r       <= out_error_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_grant_valid = out_grant_valid_r;
  assign out_granted_id  = out_granted_id_r;
  assign out_granted_vip = out_granted_vip_r;
  assign out_occupancy   = out_occupancy_r;
  assign out_error_code  = out_error_r;

endmodule

// ===== test/two_class_priority_admission_tb.sv =====
`timescale 1ns / 1ps

module two_class_priority_admission_tb;

  localparam int QUEUE_DEPTH = 16;
  localparam int QUIET_LIMIT = 500;

  // One input word and one result word as the predictor sees them.
  typedef struct {
    logic                      action;
    logic [tcpa_pkg::ID_W-1:0] client_id;
    logic                      is_vip;
  } visit_t;

  typedef struct {
    logic                       grant_valid;
    logic [tcpa_pkg::ID_W-1:0]  granted_id;
    logic                       granted_vip;
    logic [tcpa_pkg::OCC_W-1:0] occupancy;
    tcpa_pkg::tcpa_err_t        error_code;
  } admission_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_action = tcpa_pkg::ACT_ARRIVE;
  logic [tcpa_pkg::ID_W-1:0]  in_client_id = '0;
  logic                       in_is_vip = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_grant_valid;
  logic [tcpa_pkg::ID_W-1:0]  out_granted_id;
  logic                       out_granted_vip;
  logic [tcpa_pkg::OCC_W-1:0] out_occupancy;
  logic [tcpa_pkg::ERR_W-1:0] out_error_code;
  logic                       cfg_wr_en = 1'b0;
  logic [tcpa_pkg::OCC_W-1:0] cfg_wr_data = '0;

  // Stimulus and scoreboard storage.
  visit_t           pending_visits[$];
  admission_t       expected_admissions[$];

  // Predictor state.
  logic [tcpa_pkg::OCC_W-1:0] capacity_setting = tcpa_pkg::CAPACITY_RESET;
  logic [tcpa_pkg::OCC_W-1:0] occupants = '0;
  logic [tcpa_pkg::ID_W-1:0]  priority_line[$];
  logic [tcpa_pkg::ID_W-1:0]  normal_waiting[$];

  bit               calm = 1'b0;
  bit               in_taken = 1'b0;
  int unsigned      gap_left = 0;
  int unsigned      stall_left = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      words_taken = 0;
  int unsigned      grants_seen = 0;
  int unsigned      drops_seen = 0;
  int unsigned      empty_leaves_seen = 0;

  two_class_priority_admission #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_client_id   (in_client_id),
    .in_is_vip      (in_is_vip),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_grant_valid(out_grant_valid),
    .out_granted_id (out_granted_id),
    .out_granted_vip(out_granted_vip),
    .out_occupancy  (out_occupancy),
    .out_error_code (out_error_code),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one arrival or leave to the predictor state and returns the result word.
  function automatic admission_t predict_admission(visit_t v);
    admission_t r;
    logic       room;
    r.grant_valid = 1'b0;
    r.granted_id  = '0;
    r.granted_vip = 1'b0;
    r.error_code  = tcpa_pkg::ERR_OK;
    if (v.action == tcpa_pkg::ACT_ARRIVE) begin
      room = occupants < capacity_setting;
      if (v.is_vip) begin
        if (room && priority_line.size() == 0) begin
          occupants++;
          r.grant_valid = 1'b1;
          r.granted_id  = v.client_id;
          r.granted_vip = 1'b1;
        end else if (priority_line.size() < QUEUE_DEPTH) begin
          priority_line.push_back(v.client_id);
        end else begin
          r.error_code = tcpa_pkg::ERR_QUEUE_FULL;
        end
      end else begin
        // A normal arrival also waits behind any priority requester.
        if (room && normal_waiting.size() == 0 && priority_line.size() == 0) begin
          occupants++;
          r.grant_valid = 1'b1;
          r.granted_id  = v.client_id;
        end else if (normal_waiting.size() < QUEUE_DEPTH) begin
          normal_waiting.push_back(v.client_id);
        end else begin
          r.error_code = tcpa_pkg::ERR_QUEUE_FULL;
        end
      end
    end else if (occupants == 0) begin
      r.error_code = tcpa_pkg::ERR_LEAVE_EMPTY;
    end else begin
      // The freed place goes to the priority queue first.
      occupants--;
      if (occupants < capacity_setting) begin
        if (priority_line.size() != 0) begin
          r.granted_id  = priority_line.pop_front();
          r.grant_valid = 1'b1;
          r.granted_vip = 1'b1;
          occupants++;
        end else if (normal_waiting.size() != 0) begin
          r.granted_id  = normal_waiting.pop_front();
          r.grant_valid = 1'b1;
          occupants++;
        end
      end
    end
    r.occupancy = occupants;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: checks result words and predicts the outcome of every accepted word.
  always @(posedge clk) begin
    admission_t want;
    visit_t     v;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_admissions.size() == 0) begin
          $error("result word arrived with no word outstanding");
          mismatch_count++;
        end else begin
          want = expected_admissions.pop_front();
          check_field("grant_valid", want.grant_valid, out_grant_valid);
          check_field("granted_id", want.granted_id, out_granted_id);
          check_field("granted_vip", want.granted_vip, out_granted_vip);
          check_field("occupancy", want.occupancy, out_occupancy);
          check_field("error_code", want.error_code, out_error_code);
        end
      end
      if (in_valid && !in_stall) begin
        v.action    = in_action;
        v.client_id = in_client_id;
        v.is_vip    = in_is_vip;
        want = predict_admission(v);
        expected_admissions.push_back(want);
        in_taken = 1'b1;
        words_taken++;
        if (want.grant_valid) grants_seen++;
        if (want.error_code == tcpa_pkg::ERR_QUEUE_FULL) drops_seen++;
        if (want.error_code == tcpa_pkg::ERR_LEAVE_EMPTY) empty_leaves_seen++;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("two_class_priority_admission regression: fail");
        $finish;
      end
    end
  end

  // Driver: a held word stays until taken, otherwise the next one goes out or a gap opens.
  always @(negedge clk) begin
    visit_t nxt;
    if (rst_n) begin
      if (!(in_valid && !in_taken)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_visits.size() != 0) begin
          nxt = pending_visits.pop_front();
          in_valid     <= 1'b1;
          in_action    <= nxt.action;
          in_client_id <= nxt.client_id;
          in_is_vip    <= nxt.is_vip;
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // Result side back-pressure in short bursts.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_visit(input logic action, input logic [7:0] id, input logic vip);
    visit_t v;
    v.action    = action;
    v.client_id = id;
    v.is_vip    = vip;
    pending_visits.push_back(v);
  endtask

  // Waits until every word is sent and every result word has come back.
  task automatic wait_quiet();
    while (pending_visits.size() != 0 || in_valid || expected_admissions.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // One phase: new capacity while idle, then random words with the given arrival share.
  task automatic run_phase(input logic [7:0] cap, input int count, input int arrive_pct);
    visit_t v;
    wait_quiet();
    @(negedge clk);
    cfg_wr_data = cap;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    capacity_setting = cap;
    for (int k = 0; k < count; k++) begin
      v.action    = ($urandom_range(0, 99) < arrive_pct) ? tcpa_pkg::ACT_ARRIVE
                                                          : tcpa_pkg::ACT_LEAVE;
      v.client_id = $urandom_range(0, 255);
      v.is_vip    = $urandom_range(0, 1);
      pending_visits.push_back(v);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed start at the reset capacity of five.
    queue_visit(tcpa_pkg::ACT_LEAVE, 8'h3C, 1'b1);   // leave with nobody inside
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'hFF, 1'b1);
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'h00, 1'b0);
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'hAA, 1'b0);
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'h55, 1'b1);
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'h01, 1'b0);  // now full
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'h7F, 1'b0);
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'h80, 1'b1);
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'h12, 1'b1);
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'h34, 1'b0);
    // Leaves admit the priority queue first, then the normal one.
    queue_visit(tcpa_pkg::ACT_LEAVE, 8'hFF, 1'b0);
    queue_visit(tcpa_pkg::ACT_LEAVE, 8'h00, 1'b1);
    queue_visit(tcpa_pkg::ACT_LEAVE, 8'hC3, 1'b0);
    queue_visit(tcpa_pkg::ACT_LEAVE, 8'h5A, 1'b1);
    queue_visit(tcpa_pkg::ACT_LEAVE, 8'h00, 1'b0);
    queue_visit(tcpa_pkg::ACT_ARRIVE, 8'h0F, 1'b1);
    for (int k = 0; k < 6; k++) queue_visit(tcpa_pkg::ACT_LEAVE, 8'hF0, 1'b1);

    // Fill up wide open, then freeze admissions, then lower and vary the limit.
    run_phase(8'd255, 90, 85);
    run_phase(8'd0, 50, 85);
    run_phase(8'd2, 130, 40);
    run_phase(8'd1, 80, 50);
    run_phase(8'($urandom_range(4, 12)), 80, 55);
    run_phase(8'd200, 60, 55);
    wait_quiet();
    calm = 1'b1;
    run_phase(8'($urandom_range(1, 16)), 50, 55);

    wait_quiet();
    repeat (10) @(posedge clk);
    $display("Checked %0d words over capacities 0, 1, 2, 5, 200 and 255 plus random ones.",
             words_taken);
    $display("Saw %0d admissions, %0d queue-full drops and %0d leaves with nobody inside.",
             grants_seen, drops_seen, empty_leaves_seen);
    if (mismatch_count == 0) begin
      $display("two_class_priority_admission regression: pass");
    end else begin
      $display("two_class_priority_admission regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tcpa_pkg.sv
rtl/core/tcpa_queue.sv
rtl/core/two_class_priority_admission.sv
test/two_class_priority_admission_tb.sv
